/* hw/rtl/lsh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types, constants and helpers for the Laplacian sharpening stream.
// ----------------------------------------------------------------------------
package lsh_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int PIX_W      = CHAN_W * NUM_CHAN;
    localparam int DIM_REG_W  = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MIN_DIM    = 3;

    localparam logic [DIM_REG_W-1:0] CFG_WIDTH_RST  = 12'd640;
    localparam logic [DIM_REG_W-1:0] CFG_HEIGHT_RST = 12'd480;

    // Register select, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    // Per-transfer result request from the pointer control
    typedef struct packed {
        logic emit;
        logic border;
        logic last;
    } t_req;

    function automatic int unsigned clamp_dim(input logic [DIM_REG_W-1:0] v,
                                              input int unsigned hi);
        int unsigned r;
        r = int'(v);
        if (r < MIN_DIM) begin
            r = MIN_DIM;
        end else if (r > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/lsh_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_ram
// Generic RAM: one write port, NRD registered read ports (read-first).
// ----------------------------------------------------------------------------
module lsh_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 4097,
    parameter int NRD    = 2,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [DATA_W-1:0]          i_wdata,
    input  logic                       i_re,
    input  logic [NRD-1:0][AW-1:0]     i_raddr,
    output logic [NRD-1:0][DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            for (int p = 0; p < NRD; p++) begin
                o_rdata[p] <= r_mem[i_raddr[p]];
            end
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/lsh_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_lane
// One colour channel: five-point Laplacian sharpen with saturation, or bypass
// on border pixels.
// ----------------------------------------------------------------------------
module lsh_lane (
    input  logic                      i_border,
    input  logic [lsh_pkg::CHAN_W-1:0] i_c,
    input  logic [lsh_pkg::CHAN_W-1:0] i_u,
    input  logic [lsh_pkg::CHAN_W-1:0] i_l,
    input  logic [lsh_pkg::CHAN_W-1:0] i_r,
    input  logic [lsh_pkg::CHAN_W-1:0] i_d,
    output logic [lsh_pkg::CHAN_W-1:0] o_pix
);

    localparam int ACC_W = lsh_pkg::CHAN_W + 4;

    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-3:0]        quo;

    always_comb begin
        acc = $signed({1'b0, i_c, 3'b000})
            - $signed({4'b0000, i_u}) - $signed({4'b0000, i_l})
            - $signed({4'b0000, i_r}) - $signed({4'b0000, i_d});
        // negative sums truncate to zero or below, so saturate straight to 0
        quo = acc[ACC_W-1:2];
        if (i_border) begin
            o_pix = i_c;
        end else if (acc < 0) begin
            o_pix = '0;
        end else if (quo > (ACC_W-2)'(255)) begin
            o_pix = '1;
        end else begin
            o_pix = quo[lsh_pkg::CHAN_W-1:0];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/lsh_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_ctrl
// Ring pointers, pending count and output position; generates the write
// address and the centre and four neighbour read addresses for each transfer.
// ----------------------------------------------------------------------------
module lsh_ctrl #(
    parameter int MAX_WIDTH  = lsh_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lsh_pkg::MAX_HEIGHT_DEF,
    localparam int WW        = $clog2(MAX_WIDTH + 1),
    localparam int HW        = $clog2(MAX_HEIGHT + 1),
    localparam int DEPTH     = 2 * MAX_WIDTH + 1,
    localparam int AW        = $clog2(DEPTH),
    localparam int RW        = $clog2(DEPTH + 1),
    localparam int PW        = $clog2(MAX_WIDTH + 2)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_restart,
    input  logic          i_accept,
    input  lsh_pkg::t_cmd i_cmd,
    input  logic [WW-1:0] i_width,
    input  logic [HW-1:0] i_height,
    input  logic [RW-1:0] i_ring,
    output lsh_pkg::t_req o_req,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [AW-1:0] o_raddr_c,
    output logic [AW-1:0] o_raddr_u,
    output logic [AW-1:0] o_raddr_d,
    output logic [AW-1:0] o_raddr_l,
    output logic [AW-1:0] o_raddr_r
);

    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_out_ptr, n_out_ptr;
    logic [PW-1:0] r_pending, n_pending;
    logic [WW-1:0] r_col, n_col;
    logic [HW-1:0] r_row, n_row;
    logic [AW:0]   ring_x;
    logic [AW:0]   sum_dn;
    logic [AW:0]   sum_up;
    logic [AW-1:0] ring_top;
    logic          is_pixel;
    logic          col_end;
    logic          row_end;

    always_comb begin
        ring_x   = (AW+1)'(i_ring);
        ring_top = AW'(i_ring - RW'(1));
        sum_dn   = {1'b0, r_out_ptr} + (AW+1)'(i_width);
        sum_up   = sum_dn + (AW+1)'(1);
        is_pixel = (i_cmd == lsh_pkg::CMD_PIXEL);
        col_end  = (r_col == i_width - WW'(1));
        row_end  = (r_row == i_height - HW'(1));

        o_raddr_c = r_out_ptr;
        o_raddr_d = (sum_dn >= ring_x) ? AW'(sum_dn - ring_x) : AW'(sum_dn);
        o_raddr_u = (sum_up >= ring_x) ? AW'(sum_up - ring_x) : AW'(sum_up);
        o_raddr_r = (r_out_ptr == ring_top) ? '0 : r_out_ptr + AW'(1);
        o_raddr_l = (r_out_ptr == '0) ? ring_top : r_out_ptr - AW'(1);

        if (is_pixel) begin
            o_req.emit = (r_pending >= PW'(i_width) + PW'(1));
        end else begin
            o_req.emit = (r_pending != '0);
        end
        o_req.border = (r_row == '0) || row_end || (r_col == '0) || col_end;
        o_req.last   = row_end && col_end;

        o_we    = i_accept && is_pixel;
        o_waddr = r_wr_ptr;
    end

    always_comb begin
        n_wr_ptr  = r_wr_ptr;
        n_out_ptr = r_out_ptr;
        n_pending = r_pending;
        n_col     = r_col;
        n_row     = r_row;
        if (i_accept) begin
            if (is_pixel) begin
                n_wr_ptr = (r_wr_ptr == ring_top) ? '0 : r_wr_ptr + AW'(1);
            end
            if (o_req.emit) begin
                n_out_ptr = o_raddr_r;
                if (col_end) begin
                    n_col = '0;
                    n_row = row_end ? '0 : r_row + HW'(1);
                end else begin
                    n_col = r_col + WW'(1);
                end
            end
            if (is_pixel && !o_req.emit) begin
                n_pending = r_pending + PW'(1);
            end else if (!is_pixel && o_req.emit) begin
                n_pending = r_pending - PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_wr_ptr  <= '0;
            r_out_ptr <= '0;
            r_pending <= '0;
            r_col     <= '0;
            r_row     <= '0;
        end else begin
            r_wr_ptr  <= n_wr_ptr;
            r_out_ptr <= n_out_ptr;
            r_pending <= n_pending;
            r_col     <= n_col;
            r_row     <= n_row;
        end
    end

`ifndef SYNTHESIS
    a_pend_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PW'(i_width) + PW'(1))
        else $error("pending count beyond one row plus one pixel");

    a_col_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < i_width)
        else $error("output column out of range");

    a_row_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row < i_height)
        else $error("output row out of range");

    a_ptr_gap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_wr_ptr >= r_out_ptr)
            ? ({1'b0, r_wr_ptr} - {1'b0, r_out_ptr})
            : ({1'b0, r_wr_ptr} + ring_x - {1'b0, r_out_ptr}))
        == (AW+1)'(r_pending))
        else $error("ring pointer gap disagrees with pending count");
`endif

endmodule
`default_nettype wire

/* hw/rtl/laplacian_sharpen_stream.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// laplacian_sharpen_stream
// Five-point Laplacian sharpening of an RGB raster stream, one pixel a clock.
// ----------------------------------------------------------------------------
// Takes one transfer per clock, pixel or flush alike, while the output is not
// stalled; each result passes the line store read register, then the three
// channel lanes, into the output register. The rate is set by the line store,
// a ring of 2*MAX_WIDTH+1 pixels held in three RAM copies so that the centre
// and its four neighbours are read in the same cycle as the new pixel is
// written. A result leaves width+1 pixels after its pixel went in; flush
// transfers drain the tail one result each. Writing either size register
// restarts the frame. The store has no clearing pass and is usable straight
// out of reset.
// ----------------------------------------------------------------------------
module laplacian_sharpen_stream #(
    parameter int MAX_WIDTH  = lsh_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lsh_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lsh_pkg::PIX_W-1:0]        s_tdata,   // red, green, blue
    input  logic                             s_tuser,   // cmd
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lsh_pkg::PIX_W-1:0]        m_tdata,   // out_red, out_green, out_blue
    output logic                             m_tlast,   // last_pixel
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lsh_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [lsh_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [lsh_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = 2 * MAX_WIDTH + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(DEPTH + 1);
    localparam int CW    = lsh_pkg::CHAN_W;
    localparam int PXW   = lsh_pkg::PIX_W;
    localparam int DRW   = lsh_pkg::DIM_REG_W;

    localparam logic [WW-1:0] WIDTH_RST =
        WW'(lsh_pkg::clamp_dim(lsh_pkg::CFG_WIDTH_RST, MAX_WIDTH));
    localparam logic [HW-1:0] HEIGHT_RST =
        HW'(lsh_pkg::clamp_dim(lsh_pkg::CFG_HEIGHT_RST, MAX_HEIGHT));
    localparam logic [RW-1:0] RING_RST = RW'({WIDTH_RST, 1'b1});

    logic [DRW-1:0] r_cfg_width, r_cfg_height;
    logic [WW-1:0]  r_width, n_width;
    logic [HW-1:0]  r_height, n_height;
    logic [RW-1:0]  r_ring, n_ring;
    logic           cfg_wr;

    logic           accept;
    logic           out_free;
    logic           s1_ready;
    logic           rd_en;

    lsh_pkg::t_req  req;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [AW-1:0]  ra_c, ra_u, ra_d, ra_l, ra_r;

    logic [1:0][PXW-1:0] rd_ud;
    logic [1:0][PXW-1:0] rd_lr;
    logic [0:0][PXW-1:0] rd_c;
    logic [PXW-1:0]      lane_px;

    logic           r_s1_valid;
    logic           r_s1_border;
    logic           r_s1_last;
    logic           r_out_valid;
    logic [PXW-1:0] r_out_data;
    logic           r_out_last;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_width  = WW'(lsh_pkg::clamp_dim(pwdata[DRW-1:0], MAX_WIDTH));
        n_height = HW'(lsh_pkg::clamp_dim(pwdata[DRW-1:0], MAX_HEIGHT));
        n_ring   = RW'({n_width, 1'b1});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= lsh_pkg::CFG_WIDTH_RST;
            r_cfg_height <= lsh_pkg::CFG_HEIGHT_RST;
            r_width      <= WIDTH_RST;
            r_height     <= HEIGHT_RST;
            r_ring       <= RING_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                lsh_pkg::REG_WIDTH: begin
                    r_cfg_width <= pwdata[DRW-1:0];
                    r_width     <= n_width;
                    r_ring      <= n_ring;
                end
                lsh_pkg::REG_HEIGHT: begin
                    r_cfg_height <= pwdata[DRW-1:0];
                    r_height     <= n_height;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            lsh_pkg::REG_WIDTH:  prdata = lsh_pkg::CFG_DATA_W'(r_cfg_width);
            lsh_pkg::REG_HEIGHT: prdata = lsh_pkg::CFG_DATA_W'(r_cfg_height);
            default:             prdata = '0;
        endcase
    end

    // Handshake
    assign out_free = !r_out_valid || m_tready;
    assign s1_ready = !r_s1_valid || out_free;
    assign s_tready = s1_ready;
    assign accept   = s_tvalid && s_tready;
    assign rd_en    = accept && req.emit;

    lsh_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_wr),
        .i_accept  (accept),
        .i_cmd     (lsh_pkg::t_cmd'(s_tuser)),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_ring    (r_ring),
        .o_req     (req),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_raddr_c (ra_c),
        .o_raddr_u (ra_u),
        .o_raddr_d (ra_d),
        .o_raddr_l (ra_l),
        .o_raddr_r (ra_r)
    );

    lsh_ram #(.DATA_W(PXW), .DEPTH(DEPTH), .NRD(2)) u_ram_ud (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (s_tdata),
        .i_re    (rd_en),
        .i_raddr ({ra_d, ra_u}),
        .o_rdata (rd_ud)
    );

    lsh_ram #(.DATA_W(PXW), .DEPTH(DEPTH), .NRD(2)) u_ram_lr (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (s_tdata),
        .i_re    (rd_en),
        .i_raddr ({ra_r, ra_l}),
        .o_rdata (rd_lr)
    );

    lsh_ram #(.DATA_W(PXW), .DEPTH(DEPTH), .NRD(1)) u_ram_c (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (s_tdata),
        .i_re    (rd_en),
        .i_raddr (ra_c),
        .o_rdata (rd_c)
    );

    for (genvar k = 0; k < lsh_pkg::NUM_CHAN; k++) begin : g_lane
        lsh_lane u_lane (
            .i_border (r_s1_border),
            .i_c      (rd_c[0][k*CW +: CW]),
            .i_u      (rd_ud[0][k*CW +: CW]),
            .i_d      (rd_ud[1][k*CW +: CW]),
            .i_l      (rd_lr[0][k*CW +: CW]),
            .i_r      (rd_lr[1][k*CW +: CW]),
            .o_pix    (lane_px[k*CW +: CW])
        );
    end

    // Read stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= rd_en;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_border <= req.border;
            r_s1_last   <= req.last;
        end
        if (out_free) begin
            r_out_data <= lane_px;
            r_out_last <= r_s1_last;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tlast  = r_out_last;

endmodule
`default_nettype wire
